>>> rtl/core/jac_pkg.sv
// Package for the joystick axis conditioner: widths, axis slots, register indexes,
// reset values, direction bits, axis side codes, the state encoding of the
// sequencer and the divider handshake. No dependencies.
`default_nettype none

package jac_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int DIR_BITS    = 6;
   localparam int XV_BITS     = 11;
   localparam int YV_BITS     = 11;
   localparam int ZV_BITS     = 9;
   localparam int XY_SHIFT    = 1;
   localparam int Z_SHIFT     = 3;
   localparam int NUM_AXES    = 3;
   localparam int AXIS_BITS   = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS + 1);

   // Axis slots
   localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEG_END   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEG_START = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POS_START = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POS_END   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_DIV  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAT_VALUE = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_BITS-1:0] RST_NEG_END   = SAMPLE_BITS'(100);
   localparam logic [SAMPLE_BITS-1:0] RST_NEG_START = SAMPLE_BITS'(1900);
   localparam logic [SAMPLE_BITS-1:0] RST_POS_START = SAMPLE_BITS'(2200);
   localparam logic [SAMPLE_BITS-1:0] RST_POS_END   = SAMPLE_BITS'(4000);
   localparam logic [SAMPLE_BITS-1:0] RST_STEP_DIV  = SAMPLE_BITS'(8);
   localparam logic [SAMPLE_BITS-1:0] RST_SAT_VALUE = SAMPLE_BITS'(255);

   // Direction bit positions
   localparam int DIR_LEFT  = 0;
   localparam int DIR_RIGHT = 1;
   localparam int DIR_UP    = 2;
   localparam int DIR_DOWN  = 3;
   localparam int DIR_TELE  = 4;
   localparam int DIR_WIDE  = 5;

   typedef enum logic [1:0] {
      SIDE_NONE = 2'd0,
      SIDE_NEG  = 2'd1,
      SIDE_POS  = 2'd2
   } side_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SETUP  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // Handshake between the sequencer and the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> rtl/core/joystick_axis_conditioner.sv
// Joystick axis conditioner top level: sequencer, threshold checks, report
// decision and result register. Depends on jac_pkg and jac_divider.
//
// Takes one request holding an averaged sample per axis (X, Y, Z) and works
// through the axes one after another on a single shared 12-step divider. Each
// axis goes through a setup step, twelve divide steps and a capture; req_ready is
// low from acceptance to the report decision. A report, when one is made, sits in
// the result register until taken, and the next request is accepted while it
// waits. If that next request finishes while the old report is still held, the
// block holds in its final step until the result register frees. Configuration
// registers are written through the csr_ port with no wait; the user must write
// them only while idle, as the block itself does not enforce it.
`default_nettype none

module joystick_axis_conditioner
   import jac_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [SAMPLE_BITS-1:0]  req_x_sample,
   input  wire logic [SAMPLE_BITS-1:0]  req_y_sample,
   input  wire logic [SAMPLE_BITS-1:0]  req_z_sample,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [DIR_BITS-1:0]          rsp_direction_bits,
   output logic [XV_BITS-1:0]           rsp_x_value,
   output logic [YV_BITS-1:0]           rsp_y_value,
   output logic [ZV_BITS-1:0]           rsp_z_value,
   // configuration write port
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [SAMPLE_BITS-1:0]  csr_wr_data
);

   // Configuration registers
   logic [SAMPLE_BITS-1:0] neg_end_ff, neg_start_ff, pos_start_ff, pos_end_ff;
   logic [SAMPLE_BITS-1:0] step_div_ff, sat_value_ff;

   // Sequencer
   state_type               state_ff, state_in;
   logic [AXIS_BITS-1:0]    axis_ff, axis_in;
   logic                    sat_ff, sat_in;
   logic [SAMPLE_BITS-1:0]  samp_ff [NUM_AXES];
   logic [SAMPLE_BITS-1:0]  samp_in [NUM_AXES];
   logic [SAMPLE_BITS-1:0]  mag_ff  [NUM_AXES];
   logic [SAMPLE_BITS-1:0]  mag_in  [NUM_AXES];
   side_type                side_ff [NUM_AXES];
   side_type                side_in [NUM_AXES];

   // History
   logic [DIR_BITS-1:0]     last_dir_ff, last_dir_in;
   logic [XV_BITS-1:0]      last_x_ff, last_x_in;
   logic [YV_BITS-1:0]      last_y_ff, last_y_in;
   logic [ZV_BITS-1:0]      last_z_ff, last_z_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIR_BITS-1:0]     rsp_dir_ff, rsp_dir_in;
   logic [XV_BITS-1:0]      rsp_x_ff, rsp_x_in;
   logic [YV_BITS-1:0]      rsp_y_ff, rsp_y_in;
   logic [ZV_BITS-1:0]      rsp_z_ff, rsp_z_in;

   // Divider hookup
   logic                    div_start;
   logic [SAMPLE_BITS-1:0]  div_dividend;
   div_status_type          div_status;
   logic [SAMPLE_BITS-1:0]  div_quotient;

   // Setup-cycle classification of the current axis
   logic [SAMPLE_BITS-1:0]  cur_samp;
   logic                    is_neg, is_pos;

   // Report decision
   logic [DIR_BITS-1:0]     dir;
   logic [XV_BITS-1:0]      xv;
   logic [YV_BITS-1:0]      yv;
   logic [ZV_BITS-1:0]      zv;
   logic                    slot_free;
   logic                    report;

   jac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (step_div_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         neg_end_ff   <= RST_NEG_END;
         neg_start_ff <= RST_NEG_START;
         pos_start_ff <= RST_POS_START;
         pos_end_ff   <= RST_POS_END;
         step_div_ff  <= RST_STEP_DIV;
         sat_value_ff <= RST_SAT_VALUE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NEG_END:   neg_end_ff   <= csr_wr_data;
            CSR_NEG_START: neg_start_ff <= csr_wr_data;
            CSR_POS_START: pos_start_ff <= csr_wr_data;
            CSR_POS_END:   pos_end_ff   <= csr_wr_data;
            CSR_STEP_DIV:  step_div_ff  <= csr_wr_data;
            CSR_SAT_VALUE: sat_value_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Classify the current axis: the negative test wins where levels overlap
   assign cur_samp = samp_ff[axis_ff];
   assign is_neg   = (cur_samp <= neg_start_ff);
   assign is_pos   = !is_neg && (cur_samp >= pos_start_ff);

   always_comb begin
      if (is_neg) begin
         div_dividend = neg_start_ff - cur_samp;
      end else if (is_pos) begin
         div_dividend = cur_samp - pos_start_ff;
      end else begin
         div_dividend = '0;
      end
   end

   // Pack directions and shift the magnitudes
   assign dir[DIR_LEFT]  = (side_ff[AXIS_X] == SIDE_NEG);
   assign dir[DIR_RIGHT] = (side_ff[AXIS_X] == SIDE_POS);
   assign dir[DIR_UP]    = (side_ff[AXIS_Y] == SIDE_POS);
   assign dir[DIR_DOWN]  = (side_ff[AXIS_Y] == SIDE_NEG);
   assign dir[DIR_TELE]  = (side_ff[AXIS_Z] == SIDE_POS);
   assign dir[DIR_WIDE]  = (side_ff[AXIS_Z] == SIDE_NEG);

   assign xv = XV_BITS'(mag_ff[AXIS_X] >> XY_SHIFT);
   assign yv = YV_BITS'(mag_ff[AXIS_Y] >> XY_SHIFT);
   assign zv = ZV_BITS'(mag_ff[AXIS_Z] >> Z_SHIFT);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      sat_in       = sat_ff;
      samp_in      = samp_ff;
      mag_in       = mag_ff;
      side_in      = side_ff;
      last_dir_in  = last_dir_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      last_z_in    = last_z_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dir_in   = rsp_dir_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      div_start    = 1'b0;
      report       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // latch all three samples and start with X
            if (req_valid) begin
               samp_in[AXIS_X] = req_x_sample;
               samp_in[AXIS_Y] = req_y_sample;
               samp_in[AXIS_Z] = req_z_sample;
               axis_in         = AXIS_X;
               state_in        = ST_SETUP;
            end
         end

         ST_SETUP: begin
            if (is_neg) begin
               side_in[axis_ff] = SIDE_NEG;
               sat_in           = (cur_samp <= neg_end_ff);
            end else if (is_pos) begin
               side_in[axis_ff] = SIDE_POS;
               sat_in           = (cur_samp >= pos_end_ff);
            end else begin
               side_in[axis_ff] = SIDE_NONE;
               sat_in           = 1'b0;
            end
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end

         ST_DIVIDE: begin
            // capture the magnitude, then advance to the next axis or, after Z, to emit
            if (div_status.done) begin
               if (side_ff[axis_ff] == SIDE_NONE) begin
                  mag_in[axis_ff] = '0;
               end else if (sat_ff) begin
                  mag_in[axis_ff] = sat_value_ff;
               end else begin
                  mag_in[axis_ff] = div_quotient;
               end
               if (axis_ff == AXIS_Z) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in  = axis_ff + AXIS_BITS'(1);
                  state_in = ST_SETUP;
               end
            end
         end

         ST_EMIT: begin
            // hold until the result register can take a new report
            if (slot_free) begin
               if (dir == '0) begin
                  // back to center: one all-zero report, then clear history
                  if (last_dir_ff != '0) begin
                     report      = 1'b1;
                     last_dir_in = '0;
                     last_x_in   = '0;
                     last_y_in   = '0;
                     last_z_in   = '0;
                  end
               end else if (dir == last_dir_ff) begin
                  if ((dir[DIR_LEFT] || dir[DIR_RIGHT]) && xv != last_x_ff) begin
                     report    = 1'b1;
                     last_x_in = xv;
                  end
                  if ((dir[DIR_UP] || dir[DIR_DOWN]) && yv != last_y_ff) begin
                     report    = 1'b1;
                     last_y_in = yv;
                  end
                  if ((dir[DIR_TELE] || dir[DIR_WIDE]) && zv != last_z_ff) begin
                     report    = 1'b1;
                     last_z_in = zv;
                  end
               end else begin
                  // new direction set: old values stay for later compares
                  report      = 1'b1;
                  last_dir_in = dir;
               end

               if (report) begin
                  rsp_valid_in = 1'b1;
                  rsp_dir_in   = dir;
                  if (dir == '0) begin
                     rsp_x_in = '0;
                     rsp_y_in = '0;
                     rsp_z_in = '0;
                  end else begin
                     rsp_x_in = xv;
                     rsp_y_in = yv;
                     rsp_z_in = zv;
                  end
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         last_dir_ff  <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_z_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         last_dir_ff  <= last_dir_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         last_z_ff    <= last_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sat_ff     <= sat_in;
      samp_ff    <= samp_in;
      mag_ff     <= mag_in;
      side_ff    <= side_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_direction_bits = rsp_dir_ff;
   assign rsp_x_value        = rsp_x_ff;
   assign rsp_y_value        = rsp_y_ff;
   assign rsp_z_value        = rsp_z_ff;

endmodule

`default_nettype wire

>>> rtl/core/jac_divider.sv
// Shared restoring divider: one quotient bit per cycle, SAMPLE_BITS steps.
// Depends on jac_pkg.
`default_nettype none

module jac_divider
   import jac_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SAMPLE_BITS-1:0] dividend,
   input  wire logic [SAMPLE_BITS-1:0] divisor,
   output div_status_type              status,
   output logic [SAMPLE_BITS-1:0]      quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]  quo_ff, quo_in;
   logic [SAMPLE_BITS-1:0]  dsr_ff, dsr_in;
   logic [SAMPLE_BITS:0]    trial;
   logic [SAMPLE_BITS:0]    diff;

   assign trial = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(SAMPLE_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         // a zero divisor acts as one
         dsr_in  = (divisor == '0) ? SAMPLE_BITS'(1) : divisor;
      end else if (busy_ff) begin
         if (!diff[SAMPLE_BITS]) begin
            rem_in = diff[SAMPLE_BITS-1:0];
            quo_in = {quo_ff[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SAMPLE_BITS-1:0];
            quo_in = {quo_ff[SAMPLE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

>>> sim/tb_joystick_axis_conditioner.sv
`timescale 1ns / 1ps
// Self-checking testbench for joystick_axis_conditioner: a directed stimulus table, then
// random stick gestures under six register settings, all scored by an in-bench predictor.
// Depends on jac_pkg and the block's RTL only.

module tb_joystick_axis_conditioner
   import jac_pkg::*;
();

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 64;   // lets a silent request still in flight finish
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_REQUESTS = 185;
   localparam int NUM_CSRS       = CSR_SAT_VALUE + 1;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

   // Index codes past the last register; writes there must be dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam int DIRS_LEFT    = 1 << DIR_LEFT;
   localparam int DIRS_ALL_POS = (1 << DIR_RIGHT) | (1 << DIR_UP) | (1 << DIR_TELE);
   localparam int DIRS_ALL_NEG = (1 << DIR_LEFT) | (1 << DIR_DOWN) | (1 << DIR_WIDE);

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic [DIR_BITS-1:0] dirs;
      logic [XV_BITS-1:0]  x_val;
      logic [YV_BITS-1:0]  y_val;
      logic [ZV_BITS-1:0]  z_val;
   } joy_report_type;

   typedef enum logic { ROW_REQUEST, ROW_REGISTER } row_kind_type;

   typedef struct {
      row_kind_type             kind;
      sample_type               x;
      sample_type               y;
      sample_type               z;
      bit                       pinned;     // expected outcome typed into the row
      bit                       pin_has;
      joy_report_type           pin_value;
      logic [CSR_IDX_BITS-1:0]  reg_index;
      sample_type               reg_data;
   } plan_row_type;

   // Block ports; the inputs are driven to known values from time zero
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   sample_type              req_x_sample = '0;
   sample_type              req_y_sample = '0;
   sample_type              req_z_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DIR_BITS-1:0]     rsp_direction_bits;
   logic [XV_BITS-1:0]      rsp_x_value;
   logic [YV_BITS-1:0]      rsp_y_value;
   logic [ZV_BITS-1:0]      rsp_z_value;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   sample_type              csr_wr_data = '0;

   joystick_axis_conditioner dut (.*);

   // Predictor copy of the registers and of the held report state
   sample_type level_cfg [NUM_CSRS] = '{RST_NEG_END, RST_NEG_START, RST_POS_START,
                                        RST_POS_END, RST_STEP_DIV, RST_SAT_VALUE};
   logic [DIR_BITS-1:0] held_dirs = '0;
   logic [XV_BITS-1:0]  held_x = '0;
   logic [YV_BITS-1:0]  held_y = '0;
   logic [ZV_BITS-1:0]  held_z = '0;

   joy_report_type pending_reports [$];
   int unsigned mismatch_count = 0;
   int unsigned reports_checked = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_run = 0;
   int unsigned cycle_count = 0;

   // Sideband from the sender: the current request carries a typed-in expectation
   logic           row_pinned = 1'b0;
   logic           pin_has = 1'b0;
   joy_report_type pin_value = '0;

   bit          source_steady = 1'b0;
   bit          sink_steady = 1'b0;
   int unsigned sink_stall = 0;

   initial forever #1 clock = ~clock;

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Magnitude of one axis before the shift; the negative test wins on overlap,
   // and the end level is checked before the division.
   function automatic sample_type axis_magnitude(input sample_type s, output side_type side);
      sample_type divisor;
      divisor = (level_cfg[CSR_STEP_DIV] == '0) ? sample_type'(1) : level_cfg[CSR_STEP_DIV];
      if (s <= level_cfg[CSR_NEG_START]) begin
         side = SIDE_NEG;
         if (s <= level_cfg[CSR_NEG_END]) return level_cfg[CSR_SAT_VALUE];
         return (level_cfg[CSR_NEG_START] - s) / divisor;
      end
      if (s >= level_cfg[CSR_POS_START]) begin
         side = SIDE_POS;
         if (s >= level_cfg[CSR_POS_END]) return level_cfg[CSR_SAT_VALUE];
         return (s - level_cfg[CSR_POS_START]) / divisor;
      end
      side = SIDE_NONE;
      return '0;
   endfunction

   // Advance the held state by one request; return 1 when a report goes out
   function automatic bit predict_report(input sample_type xs, input sample_type ys,
                                         input sample_type zs, output joy_report_type rpt);
      side_type            sx, sy, sz;
      sample_type          mx, my, mz;
      logic [DIR_BITS-1:0] dirs;
      logic [XV_BITS-1:0]  xv;
      logic [YV_BITS-1:0]  yv;
      logic [ZV_BITS-1:0]  zv;
      bit                  changed;
      mx = axis_magnitude(xs, sx);
      my = axis_magnitude(ys, sy);
      mz = axis_magnitude(zs, sz);
      dirs = '0;
      dirs[DIR_LEFT]  = (sx == SIDE_NEG);
      dirs[DIR_RIGHT] = (sx == SIDE_POS);
      dirs[DIR_UP]    = (sy == SIDE_POS);
      dirs[DIR_DOWN]  = (sy == SIDE_NEG);
      dirs[DIR_TELE]  = (sz == SIDE_POS);
      dirs[DIR_WIDE]  = (sz == SIDE_NEG);
      xv = XV_BITS'(mx >> XY_SHIFT);
      yv = YV_BITS'(my >> XY_SHIFT);
      zv = ZV_BITS'(mz >> Z_SHIFT);
      rpt = '0;
      changed = 1'b0;
      if (dirs == '0) begin
         // back in the dead zone: one all-zero report, then forget everything
         if (held_dirs == '0) return 1'b0;
         held_dirs = '0;
         held_x = '0;
         held_y = '0;
         held_z = '0;
         return 1'b1;
      end
      if (dirs == held_dirs) begin
         // only active axes count, and each one updates its own held value
         if ((dirs[DIR_LEFT] || dirs[DIR_RIGHT]) && xv != held_x) begin
            changed = 1'b1;
            held_x = xv;
         end
         if ((dirs[DIR_UP] || dirs[DIR_DOWN]) && yv != held_y) begin
            changed = 1'b1;
            held_y = yv;
         end
         if ((dirs[DIR_TELE] || dirs[DIR_WIDE]) && zv != held_z) begin
            changed = 1'b1;
            held_z = zv;
         end
      end else begin
         // new direction set: report, but leave the held values alone
         held_dirs = dirs;
         changed = 1'b1;
      end
      rpt = '{dirs: dirs, x_val: xv, y_val: yv, z_val: zv};
      return changed;
   endfunction

   // Pick a sample meant to land on one side under the current levels,
   // with extra weight on the level boundaries.
   function automatic sample_type pick_sample(input side_type side);
      int ne, ns, ps, pe, r;
      ne = level_cfg[CSR_NEG_END];
      ns = level_cfg[CSR_NEG_START];
      ps = level_cfg[CSR_POS_START];
      pe = level_cfg[CSR_POS_END];
      r = $urandom_range(0, 19);
      case (side)
         SIDE_NEG: begin
            if (r == 0) return sample_type'(ns);
            if (r == 1) return sample_type'(ne);
            if (r == 2) return sample_type'(ne + 1);
            if (r == 3) return '0;
            return sample_type'($urandom_range(0, ns));
         end
         SIDE_POS: begin
            if (r == 0) return sample_type'(ps);
            if (r == 1) return sample_type'(pe);
            if (r == 2) return sample_type'(pe - 1);
            if (r == 3) return sample_type'(SAMPLE_MAX);
            return sample_type'($urandom_range(ps, SAMPLE_MAX));
         end
         default: begin
            if (ps - ns < 2) return sample_type'($urandom);
            if (r == 0) return sample_type'(ns + 1);
            if (r == 1) return sample_type'(ps - 1);
            return sample_type'($urandom_range(ns + 1, ps - 1));
         end
      endcase
   endfunction

   function automatic plan_row_type request_row(input int xs, input int ys, input int zs,
                                                input bit pinned = 1'b0, input bit has = 1'b0,
                                                input int dirs = 0, input int xv = 0,
                                                input int yv = 0, input int zv = 0);
      plan_row_type row;
      row.kind      = ROW_REQUEST;
      row.x         = sample_type'(xs);
      row.y         = sample_type'(ys);
      row.z         = sample_type'(zs);
      row.pinned    = pinned;
      row.pin_has   = has;
      row.pin_value = '{dirs: DIR_BITS'(dirs), x_val: XV_BITS'(xv),
                        y_val: YV_BITS'(yv), z_val: ZV_BITS'(zv)};
      row.reg_index = '0;
      row.reg_data  = '0;
      return row;
   endfunction

   function automatic plan_row_type register_row(input logic [CSR_IDX_BITS-1:0] idx,
                                                 input int data);
      plan_row_type row;
      row = request_row(0, 0, 0);
      row.kind      = ROW_REGISTER;
      row.reg_index = idx;
      row.reg_data  = sample_type'(data);
      return row;
   endfunction

   // Present one request and hold it until accepted. Called and returns at a
   // falling edge; valid stays high across back-to-back requests.
   task automatic send_request(input sample_type xs, input sample_type ys,
                               input sample_type zs,
                               input bit pinned = 1'b0, input bit has = 1'b0,
                               input joy_report_type value = '0);
      int unsigned gap;
      if ($urandom_range(0, 63) == 0) source_steady = !source_steady;
      gap = source_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_x_sample <= xs;
      req_y_sample <= ys;
      req_z_sample <= zs;
      row_pinned   <= pinned;
      pin_has      <= has;
      pin_value    <= value;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
   endtask

   // Drop valid, hold until every report is back, then give a silent request
   // time to finish before anything touches the registers.
   task automatic settle();
      req_valid  <= 1'b0;
      row_pinned <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx, input sample_type data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx < NUM_CSRS) level_cfg[idx] = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Request side: predict on every accepted request
   always @(posedge clock) begin : accept_watch
      joy_report_type predicted;
      bit             has_report;
      if (!reset && req_valid && req_ready) begin
         has_report = predict_report(req_x_sample, req_y_sample, req_z_sample, predicted);
         if (row_pinned) begin
            // the typed-in row wins, but flag it when the predictor disagrees
            if (pin_has != has_report || (pin_has && pin_value != predicted))
               note_mismatch("table row vs predictor", 64'({has_report, predicted}),
                             64'({pin_has, pin_value}));
            if (pin_has) pending_reports.push_back(pin_value);
         end else if (has_report) begin
            pending_reports.push_back(predicted);
         end
      end
   end

   // Result side: score each accepted report against the oldest expectation
   always @(posedge clock) begin : report_watch
      joy_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            note_mismatch("report with none expected",
                          64'({rsp_direction_bits, rsp_x_value, rsp_y_value, rsp_z_value}),
                          64'(0));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_direction_bits !== want.dirs)
               note_mismatch("direction_bits", 64'(rsp_direction_bits), 64'(want.dirs));
            if (rsp_x_value !== want.x_val)
               note_mismatch("x_value", 64'(rsp_x_value), 64'(want.x_val));
            if (rsp_y_value !== want.y_val)
               note_mismatch("y_value", 64'(rsp_y_value), 64'(want.y_val));
            if (rsp_z_value !== want.z_val)
               note_mismatch("z_value", 64'(rsp_z_value), 64'(want.z_val));
            reports_checked++;
         end
      end
   end

   // Receiver: random stalls, with steady stretches where ready stays high
   always @(negedge clock) begin
      if (sink_stall != 0) begin
         rsp_ready <= 1'b0;
         sink_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (!sink_steady && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
      end
      if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Cycle limit reached with %0d reports outstanding", pending_reports.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type plan [$];
      side_type     sides [3];
      sample_type   smp [3];
      sample_type   new_cfg [NUM_CSRS];
      int           lo, ns, ps, pe;
      int unsigned  phase_start, len;
      bit           reshaped;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset levels: dead zone 1901..2199, divide by 8, saturate at 255
      plan.push_back(request_row(2048, 2048, 2048, 1, 0));
      plan.push_back(request_row(0, 2048, 2048, 1, 1, DIRS_LEFT, 127, 0, 0));
      // same set again: the held X value is still zero, so it reports once more
      plan.push_back(request_row(0, 2048, 2048, 1, 1, DIRS_LEFT, 127, 0, 0));
      plan.push_back(request_row(4095, 4095, 4095, 1, 1, DIRS_ALL_POS, 127, 127, 31));
      plan.push_back(request_row(0, 0, 0, 1, 1, DIRS_ALL_NEG, 127, 127, 31));
      plan.push_back(request_row(2048, 2048, 2048, 1, 1, 0, 0, 0, 0));
      plan.push_back(request_row(2048, 2048, 2048, 1, 0));
      plan.push_back(request_row(1900, 2048, 2048, 1, 1, DIRS_LEFT, 0, 0, 0));
      plan.push_back(request_row(1899, 2048, 2048));
      plan.push_back(request_row(1800, 2048, 2048));
      plan.push_back(request_row(101, 2048, 2048));
      plan.push_back(request_row(100, 2048, 2048));
      plan.push_back(request_row(2200, 2199, 2048));
      plan.push_back(request_row(3999, 2200, 2048));
      plan.push_back(request_row(3999, 3000, 1899));
      plan.push_back(request_row(4000, 3000, 1000));
      plan.push_back(request_row(2048, 2048, 2048));
      // Overlapping extremes: everything is negative, zero divisor, full saturation;
      // the spare indexes must not disturb any level
      plan.push_back(register_row(CSR_NEG_END, 0));
      plan.push_back(register_row(CSR_NEG_START, SAMPLE_MAX));
      plan.push_back(register_row(CSR_POS_START, 0));
      plan.push_back(register_row(CSR_POS_END, SAMPLE_MAX));
      plan.push_back(register_row(CSR_STEP_DIV, 0));
      plan.push_back(register_row(CSR_SAT_VALUE, SAMPLE_MAX));
      plan.push_back(register_row(CSR_SPARE_LO, SAMPLE_MAX));
      plan.push_back(register_row(CSR_SPARE_HI, 'hA5A));
      plan.push_back(request_row(0, 0, 0, 1, 1, DIRS_ALL_NEG, 2047, 2047, 511));
      // same set, all values zero, matching the held zeros: silent
      plan.push_back(request_row(4095, 4095, 4095, 1, 0));
      plan.push_back(request_row(1, 2, 9));
      plan.push_back(request_row(2048, 1, 4094));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REGISTER) begin
            if (i == 0 || plan[i-1].kind != ROW_REGISTER) settle();
            write_register(plan[i].reg_index, plan[i].reg_data);
         end else begin
            send_request(plan[i].x, plan[i].y, plan[i].z,
                         plan[i].pinned, plan[i].pin_has, plan[i].pin_value);
         end
      end
      settings_run = 2;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         // ordered levels by default, overridden per phase
         lo = $urandom_range(0, 1500);
         ns = lo + $urandom_range(0, 1000);
         ps = ns + $urandom_range(2, 800);
         pe = ps + $urandom_range(0, SAMPLE_MAX - ps);
         new_cfg[CSR_NEG_END]   = sample_type'(lo);
         new_cfg[CSR_NEG_START] = sample_type'(ns);
         new_cfg[CSR_POS_START] = sample_type'(ps);
         new_cfg[CSR_POS_END]   = sample_type'(pe);
         new_cfg[CSR_STEP_DIV]  = sample_type'($urandom_range(1, 64));
         new_cfg[CSR_SAT_VALUE] = sample_type'($urandom);
         case (phase)
            0: new_cfg = '{RST_NEG_END, RST_NEG_START, RST_POS_START,
                           RST_POS_END, RST_STEP_DIV, RST_SAT_VALUE};
            // one-code dead zone, zero divisor, largest saturation
            2: new_cfg = '{sample_type'(0), sample_type'(2046), sample_type'(2048),
                           sample_type'(SAMPLE_MAX), sample_type'(0),
                           sample_type'(SAMPLE_MAX)};
            3: begin
               new_cfg[CSR_STEP_DIV]  = sample_type'(SAMPLE_MAX);
               new_cfg[CSR_SAT_VALUE] = '0;
            end
            // levels in any order, overlaps included
            4: foreach (new_cfg[k]) new_cfg[k] = sample_type'($urandom);
            5: new_cfg[CSR_STEP_DIV] = sample_type'($urandom_range(1, SAMPLE_MAX));
            default: ;
         endcase
         for (int k = 0; k < NUM_CSRS; k++) write_register(CSR_IDX_BITS'(k), new_cfg[k]);
         write_register($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                        sample_type'($urandom));
         settings_run++;

         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 99) < 15) begin
               // noise: samples anywhere
               send_request(sample_type'($urandom), sample_type'($urandom),
                            sample_type'($urandom));
            end else begin
               // a gesture: hold a direction set, wobble the values, mostly let go
               foreach (sides[a]) sides[a] = side_type'($urandom_range(0, 2));
               len = $urandom_range(1, 10);
               for (int k = 0; k < len; k++) begin
                  reshaped = 1'b0;
                  if (k != 0 && $urandom_range(0, 9) == 0) begin
                     sides[$urandom_range(0, 2)] = side_type'($urandom_range(0, 2));
                     reshaped = 1'b1;
                  end
                  foreach (smp[a])
                     if (k == 0 || reshaped || $urandom_range(0, 9) < 6)
                        smp[a] = pick_sample(sides[a]);
                  send_request(smp[0], smp[1], smp[2]);
               end
               if ($urandom_range(0, 4) != 0)
                  send_request(pick_sample(SIDE_NONE), pick_sample(SIDE_NONE),
                               pick_sample(SIDE_NONE));
            end
         end
      end

      settle();
      $display("Sent %0d requests under %0d register settings (directed table, then gestures)",
               requests_sent, settings_run);
      $display("Checked %0d reports field by field; %0d mismatches",
               reports_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/jac_pkg.sv
rtl/core/jac_divider.sv
rtl/core/joystick_axis_conditioner.sv
sim/tb_joystick_axis_conditioner.sv
